// ----- hdl/gtr_pkg.sv -----
package gtr_pkg;

    localparam int NODES_DEFAULT = 64;
    localparam int VERTEX_W      = 6;
    localparam int CODE_W        = 2;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        CODE_BOTH     = 2'd0,
        CODE_FORWARD  = 2'd1,
        CODE_BACKWARD = 2'd2,
        CODE_NEITHER  = 2'd3
    } reach_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD_A,
        S_EDGE_WR_A,
        S_EDGE_RD_B,
        S_EDGE_WR_B,
        S_INIT,
        S_POP,
        S_POP_WAIT,
        S_ROW,
        S_PUSH,
        S_DONE
    } state_t;

endpackage

// ----- hdl/gtr_req_if.sv -----
interface gtr_req_if;
    import gtr_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [VERTEX_W-1:0] first_vertex;
    logic [VERTEX_W-1:0] second_vertex;
    logic                both_ways;

    modport source (
        output valid, kind, first_vertex, second_vertex, both_ways,
        input  ready
    );

    modport sink (
        input  valid, kind, first_vertex, second_vertex, both_ways,
        output ready
    );
endinterface

// ----- hdl/gtr_rsp_if.sv -----
interface gtr_rsp_if;
    import gtr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] reach_code;

    modport source (
        output valid, reach_code,
        input  ready
    );

    modport sink (
        input  valid, reach_code,
        output ready
    );
endinterface

// ----- hdl/gtr_ram.sv -----
module gtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/graph_two_way_reachability_top.sv -----
// two-way reachability over a directed graph of NODES vertices
// req channel (valid/ready): kind 0 adds the edge first_vertex -> second_vertex,
//   and the reverse edge as well when both_ways is set; it gives no result.
//   kind 1 asks whether each vertex reaches the other and gives one reach_code
//   item on the rsp channel: 0 both ways, 1 forward only, 2 backward only, 3 neither.
// an edge item with a vertex at or above NODES is dropped
// one item is worked on at a time; req.ready is high only while idle
// edge item: read-modify-write of the first vertex's adjacency row, and of the
//   second vertex's row as well with both_ways
// query: two depth-first searches over an adjacency ram and a stack ram;
//   each visited vertex takes a stack read, a row read, a row scan and a push scan
//   that pushes its unvisited neighbors one at a time, paced by the single read port
//   of each ram; equal or out-of-range vertices skip the searches and go straight to done
// the result sits in an output register: a stalled rsp.ready holds it and
//   edge items are still taken; a later query waits for that register to free
// reset clears per-row valid flags, so the graph is empty at once with no
//   clearing pass; the stack ram needs no reset
module graph_two_way_reachability_top #(
    parameter int NODES = gtr_pkg::NODES_DEFAULT
) (
    input  logic   clk,
    input  logic   rst_n,
    gtr_req_if.sink   req,
    gtr_rsp_if.source rsp
);
    import gtr_pkg::*;

    localparam int ADDR_W  = $clog2(NODES);
    localparam int DEPTH_W = $clog2(NODES + 1);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  a_reg, a_next;
    logic [ADDR_W-1:0]  b_reg, b_next;
    logic               both_reg, both_next;
    logic               dir_reg, dir_next;
    logic               fwd_reg, fwd_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [NODES-1:0]   visited_reg, visited_next;
    logic [NODES-1:0]   fresh_reg, fresh_next;
    logic [NODES-1:0]   row_valid_reg, row_valid_next;
    logic               rvalid_reg, rvalid_next;
    logic               out_valid_reg, out_valid_next;
    reach_code_t        code_reg, code_next;
    reach_code_t        out_code_reg, out_code_next;

    logic               adj_we;
    logic [ADDR_W-1:0]  adj_waddr, adj_raddr;
    logic [NODES-1:0]   adj_wdata, adj_rdata, row;
    logic               stk_we;
    logic [ADDR_W-1:0]  stk_waddr, stk_raddr, stk_rdata;
    logic [ADDR_W-1:0]  stk_wdata;

    logic               accept;
    logic               in_range;
    logic               out_free;
    logic               search_end, search_hit;
    logic [NODES-1:0]   low_bit;
    logic [ADDR_W-1:0]  low_idx;

    function automatic logic [NODES-1:0] onehot(input logic [ADDR_W-1:0] idx);
        logic [NODES-1:0] r;
        r = '0;
        r[idx] = 1'b1;
        return r;
    endfunction

    gtr_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    gtr_ram #(.WIDTH(ADDR_W), .DEPTH(NODES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign accept         = req.valid && req.ready;
    assign in_range       = (32'(req.first_vertex) < NODES) && (32'(req.second_vertex) < NODES);
    assign out_free       = !out_valid_reg || rsp.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.reach_code = out_code_reg;

    // rows never written read as empty
    assign row = rvalid_reg ? adj_rdata : '0;

    // lowest pending neighbor
    assign low_bit = fresh_reg & (~fresh_reg + 1'b1);
    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | ADDR_W'(i);
            end
        end
    end

    always_comb
    begin
        search_end = 1'b0;
        search_hit = 1'b0;
        if (state_reg == S_POP && depth_reg == '0)
        begin
            search_end = 1'b1;
        end
        if (state_reg == S_POP_WAIT && stk_rdata == b_reg)
        begin
            search_end = 1'b1;
            search_hit = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_EDGE)
                    begin
                        state_next = in_range ? S_EDGE_RD_A : S_IDLE;
                    end
                    else if (req.first_vertex == req.second_vertex || !in_range)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_EDGE_RD_A: state_next = S_EDGE_WR_A;
            S_EDGE_WR_A: state_next = both_reg ? S_EDGE_RD_B : S_IDLE;
            S_EDGE_RD_B: state_next = S_EDGE_WR_B;
            S_EDGE_WR_B: state_next = S_IDLE;
            S_INIT:      state_next = S_POP;
            S_POP:
            begin
                if (search_end)
                begin
                    state_next = dir_reg ? S_DONE : S_INIT;
                end
                else
                begin
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                if (search_end)
                begin
                    state_next = dir_reg ? S_DONE : S_INIT;
                end
                else
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:       state_next = S_PUSH;
            S_PUSH:      state_next = (fresh_reg == '0) ? S_POP : S_PUSH;
            S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        both_next      = both_reg;
        dir_next       = dir_reg;
        fwd_next       = fwd_reg;
        depth_next     = depth_reg;
        visited_next   = visited_reg;
        fresh_next     = fresh_reg;
        row_valid_next = row_valid_reg;
        code_next      = code_reg;
        out_code_next  = out_code_reg;
        out_valid_next = out_valid_reg;
        rvalid_next    = rvalid_reg;

        adj_we    = 1'b0;
        adj_waddr = a_reg;
        adj_wdata = row | onehot(b_reg);
        adj_raddr = a_reg;
        stk_we    = 1'b0;
        stk_waddr = depth_reg[ADDR_W-1:0];
        stk_wdata = low_idx;
        stk_raddr = depth_reg[ADDR_W-1:0] - 1'b1;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    a_next    = req.first_vertex[ADDR_W-1:0];
                    b_next    = req.second_vertex[ADDR_W-1:0];
                    both_next = req.both_ways;
                    dir_next  = 1'b0;
                    if (req.first_vertex == req.second_vertex)
                    begin
                        code_next = CODE_BOTH;
                    end
                    else
                    begin
                        code_next = CODE_NEITHER;
                    end
                end
            end
            S_EDGE_RD_A:
            begin
                adj_raddr   = a_reg;
                rvalid_next = row_valid_reg[a_reg];
            end
            S_EDGE_WR_A:
            begin
                adj_we                = 1'b1;
                adj_waddr             = a_reg;
                adj_wdata             = row | onehot(b_reg);
                row_valid_next[a_reg] = 1'b1;
            end
            S_EDGE_RD_B:
            begin
                adj_raddr   = b_reg;
                rvalid_next = row_valid_reg[b_reg];
            end
            S_EDGE_WR_B:
            begin
                adj_we                = 1'b1;
                adj_waddr             = b_reg;
                adj_wdata             = row | onehot(a_reg);
                row_valid_next[b_reg] = 1'b1;
            end
            S_INIT:
            begin
                stk_we       = 1'b1;
                stk_waddr    = '0;
                stk_wdata    = a_reg;
                visited_next = onehot(a_reg);
                depth_next   = DEPTH_W'(1);
            end
            S_POP:
            begin
                if (!search_end)
                begin
                    depth_next = depth_reg - 1'b1;
                    stk_raddr  = depth_reg[ADDR_W-1:0] - 1'b1;
                end
            end
            S_POP_WAIT:
            begin
                adj_raddr   = stk_rdata;
                rvalid_next = row_valid_reg[stk_rdata];
            end
            S_ROW:
            begin
                fresh_next = row & ~visited_reg;
            end
            S_PUSH:
            begin
                if (fresh_reg != '0)
                begin
                    stk_we       = 1'b1;
                    stk_waddr    = depth_reg[ADDR_W-1:0];
                    stk_wdata    = low_idx;
                    depth_next   = depth_reg + 1'b1;
                    visited_next = visited_reg | low_bit;
                    fresh_next   = fresh_reg & ~low_bit;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = code_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (search_end)
        begin
            visited_next = '0;
            depth_next   = '0;
            if (!dir_reg)
            begin
                fwd_next = search_hit;
                dir_next = 1'b1;
                a_next   = b_reg;
                b_next   = a_reg;
            end
            else if (fwd_reg && search_hit)
            begin
                code_next = CODE_BOTH;
            end
            else if (fwd_reg)
            begin
                code_next = CODE_FORWARD;
            end
            else if (search_hit)
            begin
                code_next = CODE_BACKWARD;
            end
            else
            begin
                code_next = CODE_NEITHER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            visited_reg   <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        both_reg     <= both_next;
        dir_reg      <= dir_next;
        fwd_reg      <= fwd_next;
        fresh_reg    <= fresh_next;
        rvalid_reg   <= rvalid_next;
        code_reg     <= code_next;
        out_code_reg <= out_code_next;
    end

`ifndef SYNTH
    // each vertex is pushed once, so the stack never outgrows the ram
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= NODES)
        else $error("stack depth beyond NODES");

    // pending neighbors are never already visited
    a_fresh_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> ((fresh_reg & visited_reg) == '0))
        else $error("pushing a visited vertex");

    // a result item is only loaded from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside done state");

    // a waiting result holds its code
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> $stable(out_code_reg))
        else $error("result changed while stalled");
`endif
endmodule
